[rtl/core/u8bb_pkg.sv]
// Shared types and constants of the UTF-8 byte-budget encoder.
`timescale 1ns / 1ps
`default_nettype none
package u8bb_pkg;

  localparam int unsigned CP_W     = 21;
  localparam int unsigned BUDGET_W = 16;
  localparam int unsigned COUNT_W  = 17;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'd32;
  localparam logic [7:0]          DOT_BYTE     = 8'h2E;
  localparam logic [7:0]          SPACE_BYTE   = 8'h20;

  // Register index of the byte budget on the configuration port.
  localparam logic REG_BYTE_BUDGET = 1'b0;

  // Bytes caused by one accepted item: up to three, with a count.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      n;
    logic            trunc;
  } grp_t;

endpackage
`default_nettype wire

[rtl/core/utf8_encoder_byte_budget_truncate_unit.sv]
// Top level of the UTF-8 encoder with byte budget and ellipsis truncation.
`timescale 1ns / 1ps
`default_nettype none
// The unit takes one code point per input transfer and sends its UTF-8
// encoding one byte per output transfer. The running byte count and the
// stopped flag are updated in the cycle an item is accepted, and the bytes
// that item causes are placed as one group in a two-entry queue. The output
// side drains the head group one byte per cycle while out_tready is high, so
// an item sends as many bytes as it has: one for ASCII, two or three for wider
// code points and three for the "..." ellipsis, while spaces, ignored code
// points and items after a stop are accepted and send nothing. The output
// byte port is the only limit on rate; a new item is accepted in every cycle
// in which the queue has a free entry, also while earlier bytes still wait.
// The byte budget is written through the APB-style port at any address with
// paddr[2] clear and should only be changed while no bytes are outstanding.
module utf8_encoder_byte_budget_truncate_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [20:0] code_point, [23:21] zero
  input  wire logic [0:0]  in_tuser,   // [0] first_of_string
  // Output stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast,  // last byte caused by one item
  output logic [0:0]       out_tuser,  // [0] truncated
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import u8bb_pkg::*;

  // Configuration register.
  logic [BUDGET_W-1:0] budget_r;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BYTE_BUDGET);
  assign prdata = (paddr[2] == REG_BYTE_BUDGET) ? {16'd0, budget_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_RESET;
    end else if (cfg_wr) begin
      budget_r <= pwdata[BUDGET_W-1:0];
    end
  end

  // Encoder state.
  logic [COUNT_W-1:0] used_r;
  logic [COUNT_W-1:0] used_nxt;
  logic               stopped_r;
  logic               stopped_nxt;
  grp_t               enc_grp;
  logic               in_acc;

  u8bb_encode u_encode (
    .code_point      (in_tdata[CP_W-1:0]),
    .first_of_string (in_tuser[0]),
    .byte_budget     (budget_r),
    .bytes_used      (used_r),
    .stopped         (stopped_r),
    .grp             (enc_grp),
    .bytes_used_nxt  (used_nxt),
    .stopped_nxt     (stopped_nxt)
  );

  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      stopped_r <= 1'b0;
    end else if (in_acc) begin
      used_r    <= used_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // Two-entry queue of byte groups and the byte index within the head group.
  grp_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] idx_r;
  logic       push;
  logic       pop;
  logic       out_acc;
  grp_t       head;
  logic       head_last;

  assign head      = q_r[rd_ptr_r];
  assign head_last = (idx_r == (head.n - 2'd1));
  assign push      = in_acc && (enc_grp.n != 2'd0);
  assign out_acc   = out_tvalid && out_tready;
  assign pop       = out_acc && head_last;
  assign in_tready = (cnt_r != 2'd2);

  assign out_tvalid   = (cnt_r != 2'd0);
  assign out_tdata    = head.bytes[idx_r];
  assign out_tlast    = head_last;
  assign out_tuser[0] = head.trunc;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= enc_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
      idx_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
        idx_r    <= '0;
      end else if (out_acc) begin
        idx_r <= idx_r + 2'd1;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // The queue never holds more than its two entries.
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("byte group queue overfilled");

  // A group waiting at the head always has at least one byte to send.
  assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> head.n != 2'd0)
    else $error("empty byte group at queue head");

  // The byte index stays inside the head group.
  assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> idx_r < head.n)
    else $error("byte index beyond head group");

  // Queuing an ellipsis always leaves the stream stopped.
  assert property (@(posedge clk) disable iff (!rst_n) (push && enc_grp.trunc) |=> stopped_r)
    else $error("ellipsis sent without stopping the stream");

endmodule
`default_nettype wire

[rtl/core/u8bb_encode.sv]
// Combinational encode step: cost, budget check, byte forming and next state.
`timescale 1ns / 1ps
`default_nettype none
module u8bb_encode (
  input  wire logic [u8bb_pkg::CP_W-1:0]     code_point,
  input  wire logic                          first_of_string,
  input  wire logic [u8bb_pkg::BUDGET_W-1:0] byte_budget,
  input  wire logic [u8bb_pkg::COUNT_W-1:0]  bytes_used,
  input  wire logic                          stopped,
  output u8bb_pkg::grp_t                     grp,
  output logic      [u8bb_pkg::COUNT_W-1:0]  bytes_used_nxt,
  output logic                               stopped_nxt
);
  import u8bb_pkg::*;

  logic [COUNT_W-1:0] base;
  logic               st;
  logic [1:0]         cost;
  logic [COUNT_W-1:0] total;
  logic               over;

  always_comb begin
    base = first_of_string ? '0 : bytes_used;
    st   = first_of_string ? 1'b0 : stopped;

    if (code_point <= 21'h7F) begin
      cost = 2'd1;
    end else if (code_point <= 21'h7FF) begin
      cost = 2'd2;
    end else if (code_point <= 21'hFFFF) begin
      cost = 2'd3;
    end else begin
      cost = 2'd0;
    end

    total = base + COUNT_W'(cost);
    over  = total > COUNT_W'(byte_budget);

    grp            = '0;
    bytes_used_nxt = base;
    stopped_nxt    = st;

    if (!st) begin
      if (code_point == '0) begin
        stopped_nxt = 1'b1;
      end else if (cost != 2'd0) begin
        bytes_used_nxt = total;
        if (over) begin
          grp.bytes   = {DOT_BYTE, DOT_BYTE, DOT_BYTE};
          grp.n       = 2'd3;
          grp.trunc   = 1'b1;
          stopped_nxt = 1'b1;
        end else begin
          case (cost)
            2'd1: begin
              grp.bytes[0] = code_point[7:0];
              grp.n        = (code_point[7:0] == SPACE_BYTE) ? 2'd0 : 2'd1;
            end
            2'd2: begin
              grp.bytes[0] = {3'b110, code_point[10:6]};
              grp.bytes[1] = {2'b10, code_point[5:0]};
              grp.n        = 2'd2;
            end
            default: begin
              grp.bytes[0] = {4'b1110, code_point[15:12]};
              grp.bytes[1] = {2'b10, code_point[11:6]};
              grp.bytes[2] = {2'b10, code_point[5:0]};
              grp.n        = 2'd3;
            end
          endcase
        end
      end
    end
  end

endmodule
`default_nettype wire
